[rtl/assert_macros.svh]
// assertion macros shared by the execute unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[rtl/hcpu_pkg.sv]
// package: types, opcodes and constants of the execute unit
package hcpu_pkg;

    localparam int BYTE_W      = 8;
    localparam int OPCODE_W    = 6;
    localparam int REG_FIELD_W = 2;

    localparam int DATA_DEPTH_DEF  = 256;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int NUM_REGS_DEF    = 4;

    localparam logic REQ_EXEC    = 1'b0;
    localparam logic REQ_PRELOAD = 1'b1;

    // flag byte layout for LDFL and STFL
    localparam int FLAG_CARRY = 0;
    localparam int FLAG_NEG   = 1;
    localparam int FLAG_INT   = 2;
    localparam int FLAG_HALT  = 3;

    typedef enum logic [OPCODE_W-1:0] {
        OP_NOOP = 6'd0,  OP_ST   = 6'd1,  OP_STR  = 6'd2,  OP_LD   = 6'd3,
        OP_LDR  = 6'd4,  OP_LI   = 6'd5,  OP_CP   = 6'd6,  OP_CLC  = 6'd7,
        OP_CLI  = 6'd8,  OP_CLN  = 6'd9,  OP_SUB  = 6'd10, OP_SUBI = 6'd11,
        OP_ADD  = 6'd12, OP_ADDI = 6'd13, OP_AND  = 6'd14, OP_OR   = 6'd15,
        OP_XOR  = 6'd16, OP_NOT  = 6'd17, OP_SHL  = 6'd18, OP_SHR  = 6'd19,
        OP_ANDI = 6'd20, OP_ORI  = 6'd21, OP_XORI = 6'd22, OP_JMP  = 6'd23,
        OP_JIZ  = 6'd24, OP_JNZ  = 6'd25, OP_JIC  = 6'd26, OP_JNC  = 6'd27,
        OP_JII  = 6'd28, OP_JNI  = 6'd29, OP_LDPR = 6'd30, OP_LDFL = 6'd31,
        OP_STFL = 6'd32, OP_CALL = 6'd33, OP_RET  = 6'd34, OP_WR   = 6'd35,
        OP_RD   = 6'd36
    } t_opcode;

    typedef struct packed {
        logic                   req_type;
        logic [OPCODE_W-1:0]    opcode;
        logic [REG_FIELD_W-1:0] reg_a;
        logic [REG_FIELD_W-1:0] reg_b;
        logic [BYTE_W-1:0]      imm;
        logic [BYTE_W-1:0]      in_byte;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0] next_pc;
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              in_taken;
        logic              halted;
    } t_out_word;

    typedef struct packed {
        logic                   en;
        logic [REG_FIELD_W-1:0] idx;
        logic [BYTE_W-1:0]      data;
    } t_rf_wr;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } t_dmem_ctl;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [BYTE_W-1:0] data;
    } t_stk_ctl;

endpackage

[rtl/hcpu_regfile.sv]
// register file: two synchronous read ports, one write port, per-entry valid bits
module hcpu_regfile import hcpu_pkg::*; #(
    parameter int NUM_REGS = NUM_REGS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [REG_FIELD_W-1:0] i_rd_idx_a,
    input  logic [REG_FIELD_W-1:0] i_rd_idx_b,
    input  t_rf_wr                 i_wr,
    output logic [BYTE_W-1:0]      o_rd_data_a,
    output logic [BYTE_W-1:0]      o_rd_data_b
);

    localparam int RIDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    logic [BYTE_W-1:0]   r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;
    logic [BYTE_W-1:0]   r_data_a;
    logic [BYTE_W-1:0]   r_data_b;
    logic                r_ok_a;
    logic                r_ok_b;

    logic [RIDX_W-1:0] idx_a;
    logic [RIDX_W-1:0] idx_b;
    logic [RIDX_W-1:0] idx_w;
    logic              rng_a;
    logic              rng_b;
    logic              wr_ok;

    assign idx_a = RIDX_W'(i_rd_idx_a);
    assign idx_b = RIDX_W'(i_rd_idx_b);
    assign idx_w = RIDX_W'(i_wr.idx);
    assign rng_a = (int'(i_rd_idx_a) < NUM_REGS);
    assign rng_b = (int'(i_rd_idx_b) < NUM_REGS);
    assign wr_ok = i_wr.en && (int'(i_wr.idx) < NUM_REGS);

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ok_a <= 1'b0;
            r_ok_b <= 1'b0;
        end else begin
            r_ok_a <= rng_a && r_vld[idx_a];
            r_ok_b <= rng_b && r_vld[idx_b];
            if (wr_ok) begin
                r_vld[idx_w] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data_a <= r_mem[idx_a];
        r_data_b <= r_mem[idx_b];
        if (wr_ok) begin
            r_mem[idx_w] <= i_wr.data;
        end
    end

    assign o_rd_data_a = r_ok_a ? r_data_a : '0;
    assign o_rd_data_b = r_ok_b ? r_data_b : '0;

endmodule

[rtl/hcpu_dmem.sv]
// data memory: one port, registered read, zeroing sweep after reset
module hcpu_dmem import hcpu_pkg::*; #(
    parameter int DATA_DEPTH = DATA_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dmem_ctl         i_ctl,
    output logic [BYTE_W-1:0] o_rdata,
    output logic              o_busy
);

    localparam int AW = $clog2(DATA_DEPTH);

    logic [BYTE_W-1:0] r_mem [DATA_DEPTH];
    logic [BYTE_W-1:0] r_rdata;
    logic              r_rd_ok;
    logic              r_clr_busy;
    logic [AW-1:0]     r_clr_addr;

    logic              in_rng;
    logic [AW-1:0]     addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;

    assign in_rng  = (int'(i_ctl.addr) < DATA_DEPTH);
    assign addr    = AW'(i_ctl.addr);
    assign wr_en   = r_clr_busy || (i_ctl.wr_en && in_rng);
    assign wr_addr = r_clr_busy ? r_clr_addr : addr;
    assign wr_data = r_clr_busy ? '0 : i_ctl.wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_rd_ok    <= 1'b0;
        end else begin
            if (i_ctl.rd_en) begin
                r_rd_ok <= in_rng;
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DATA_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // addresses beyond the memory read as zero
    assign o_rdata = r_rd_ok ? r_rdata : '0;
    assign o_busy  = r_clr_busy;

endmodule

[rtl/hcpu_rstack.sv]
// return stack: circular memory with top pointer and fill count, oldest dropped on overflow
module hcpu_rstack import hcpu_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_stk_ctl          i_ctl,
    output logic [BYTE_W-1:0] o_top,
    output logic              o_empty
);

    localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FW   = $clog2(STACK_DEPTH + 1);

    logic [BYTE_W-1:0] r_mem [STACK_DEPTH];
    logic [BYTE_W-1:0] r_top;
    logic [SP_W-1:0]   r_sp;
    logic [FW-1:0]     r_fill;

    logic [SP_W-1:0]   rd_ptr;
    logic [SP_W-1:0]   sp_inc;

    // r_sp is the next free slot, the top entry sits just below it
    assign rd_ptr = (r_sp == '0) ? SP_W'(STACK_DEPTH - 1) : r_sp - 1'b1;
    assign sp_inc = (r_sp == SP_W'(STACK_DEPTH - 1)) ? '0 : r_sp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp   <= '0;
            r_fill <= '0;
        end else if (i_ctl.push) begin
            r_sp <= sp_inc;
            if (r_fill != FW'(STACK_DEPTH)) begin
                r_fill <= r_fill + 1'b1;
            end
        end else if (i_ctl.pop && (r_fill != '0)) begin
            r_sp   <= rd_ptr;
            r_fill <= r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= r_mem[rd_ptr];
        if (i_ctl.push) begin
            r_mem[r_sp] <= i_ctl.data;
        end
    end

    assign o_top   = r_top;
    assign o_empty = (r_fill == '0);

endmodule

[rtl/harvard_cpu_execute_unit.sv]
// top level: execute stage of the 8-bit harvard cpu with output buffer
// the taken input word is registered into the execute stage, and its result into the output buffer
// a new word is not taken while one is in execute; the register file read sits before execute
// loads write the register file in the cycle after execute, forwarded into the next word
// reset: control state clears, then the data memory is zeroed while input is held off

`include "assert_macros.svh"

module harvard_cpu_execute_unit import hcpu_pkg::*; #(
    parameter int DATA_DEPTH  = DATA_DEPTH_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int NUM_REGS    = NUM_REGS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    // execute stage: holds the word for the cycle after it is taken
    logic      r_s1_valid;
    t_in_word  r_s1_item;

    // architectural state kept in flops
    logic [BYTE_W-1:0] r_pc;
    logic              r_carry;
    logic              r_neg;
    logic              r_int;
    logic              r_halt;
    logic [BYTE_W-1:0] n_pc;
    logic              n_carry;
    logic              n_neg;
    logic              n_int;
    logic              n_halt;

    // load writeback stage
    logic                   r_s2_wb;
    logic [REG_FIELD_W-1:0] r_s2_idx;
    logic                   n_s2_wb;

    // forwarding of a load result into a word whose register read raced it
    logic                   r_fwd_valid;
    logic [REG_FIELD_W-1:0] r_fwd_idx;
    logic [BYTE_W-1:0]      r_fwd_data;

    // two-entry output buffer
    t_out_word r_oq0;
    t_out_word r_oq1;
    logic [1:0] r_out_cnt;
    t_out_word n_oq0;
    t_out_word n_oq1;
    logic [1:0] n_out_cnt;

    logic      accept;
    logic      push;
    logic      pop;
    t_out_word res;

    // memory interfaces
    t_rf_wr            rf_wr_exec;
    t_rf_wr            rf_wr;
    logic [BYTE_W-1:0] rf_a;
    logic [BYTE_W-1:0] rf_b;
    t_dmem_ctl         dmem_ctl;
    logic [BYTE_W-1:0] dmem_rdata;
    logic              dmem_busy;
    t_stk_ctl          stk_ctl;
    logic [BYTE_W-1:0] stk_top;
    logic              stk_empty;

    // operands and datapath
    logic [BYTE_W-1:0] va;
    logic [BYTE_W-1:0] vb;
    logic [BYTE_W-1:0] add_rhs;
    logic [BYTE_W-1:0] sub_rhs;
    logic [BYTE_W:0]   add_sum;
    logic [BYTE_W:0]   sub_diff;
    logic              sub_neg;
    logic [BYTE_W-1:0] sub_mag;
    logic              ra_ok;
    logic              jump;
    logic [BYTE_W-1:0] pc_base;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_s1_valid && !dmem_busy && (r_out_cnt != 2'd2);

    hcpu_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_idx_a  (i_in_word.reg_a),
        .i_rd_idx_b  (i_in_word.reg_b),
        .i_wr        (rf_wr),
        .o_rd_data_a (rf_a),
        .o_rd_data_b (rf_b)
    );

    hcpu_dmem #(
        .DATA_DEPTH (DATA_DEPTH)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dmem_ctl),
        .o_rdata (dmem_rdata),
        .o_busy  (dmem_busy)
    );

    hcpu_rstack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_rstack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stk_ctl),
        .o_top   (stk_top),
        .o_empty (stk_empty)
    );

    // operand fetch with bypass of a load written back on the same edge as the read
    assign va = (r_fwd_valid && (r_fwd_idx == r_s1_item.reg_a)) ? r_fwd_data : rf_a;
    assign vb = (r_fwd_valid && (r_fwd_idx == r_s1_item.reg_b)) ? r_fwd_data : rf_b;
    assign ra_ok = (int'(r_s1_item.reg_a) < NUM_REGS);

    // add with carry out, subtract giving magnitude and sign
    assign add_rhs  = (r_s1_item.opcode == OP_ADDI) ? r_s1_item.imm : vb;
    assign sub_rhs  = (r_s1_item.opcode == OP_SUBI) ? r_s1_item.imm : vb;
    assign add_sum  = {1'b0, va} + {1'b0, add_rhs};
    assign sub_diff = {1'b0, va} - {1'b0, sub_rhs};
    assign sub_neg  = sub_diff[BYTE_W];
    assign sub_mag  = sub_neg ? (sub_rhs - va) : sub_diff[BYTE_W-1:0];

    // execute: everything but the load result settles in this cycle
    always_comb begin
        n_pc       = r_pc;
        n_carry    = r_carry;
        n_neg      = r_neg;
        n_int      = r_int;
        n_halt     = r_halt;
        n_s2_wb    = 1'b0;
        rf_wr_exec = '0;
        rf_wr_exec.idx = r_s1_item.reg_a;
        dmem_ctl   = '0;
        stk_ctl    = '0;
        stk_ctl.data = r_pc;
        jump       = 1'b0;
        pc_base    = r_pc;
        res        = '0;

        if (r_s1_valid) begin
            if (r_s1_item.req_type == REQ_PRELOAD) begin
                dmem_ctl.wr_en = 1'b1;
                dmem_ctl.addr  = r_s1_item.imm;
                dmem_ctl.wdata = r_s1_item.in_byte;
            end else if (!r_halt) begin
                case (r_s1_item.opcode)
                    OP_ST: begin
                        dmem_ctl.wr_en = 1'b1;
                        dmem_ctl.addr  = r_s1_item.imm;
                        dmem_ctl.wdata = va;
                    end
                    OP_STR: begin
                        dmem_ctl.wr_en = 1'b1;
                        dmem_ctl.addr  = va;
                        dmem_ctl.wdata = vb;
                    end
                    OP_LD: begin
                        dmem_ctl.rd_en = 1'b1;
                        dmem_ctl.addr  = r_s1_item.imm;
                        n_s2_wb        = ra_ok;
                    end
                    OP_LDR: begin
                        dmem_ctl.rd_en = 1'b1;
                        dmem_ctl.addr  = vb;
                        n_s2_wb        = ra_ok;
                    end
                    OP_LI: begin
                        rf_wr_exec.en   = 1'b1;
                        rf_wr_exec.data = r_s1_item.imm;
                    end
                    OP_CP: begin
                        rf_wr_exec.en   = 1'b1;
                        rf_wr_exec.data = vb;
                    end
                    OP_CLC: begin
                        n_carry = 1'b0;
                    end
                    OP_CLI: begin
                        n_int = 1'b0;
                    end
                    OP_CLN: begin
                        n_neg = 1'b0;
                    end
                    OP_SUB, OP_SUBI: begin
                        rf_wr_exec.en   = 1'b1;
                        rf_wr_exec.data = sub_mag;
                        n_neg           = sub_neg;
                    end
                    OP_ADD, OP_ADDI: begin
                        rf_wr_exec.en   = 1'b1;
                        rf_wr_exec.data = add_sum[BYTE_W-1:0];
                        n_carry         = add_sum[BYTE_W];
                    end
                    OP_AND: begin
                        rf_wr_exec.en   = 1'b1;
                        rf_wr_exec.data = va & vb;
                    end
                    OP_OR: begin
                        rf_wr_exec.en   = 1'b1;
                        rf_wr_exec.data = va | vb;
                    end
                    OP_XOR: begin
                        rf_wr_exec.en   = 1'b1;
                        rf_wr_exec.data = va ^ vb;
                    end
                    OP_NOT: begin
                        rf_wr_exec.en   = 1'b1;
                        rf_wr_exec.data = ~va;
                    end
                    OP_SHL: begin
                        rf_wr_exec.en   = 1'b1;
                        rf_wr_exec.data = {va[BYTE_W-2:0], 1'b0};
                    end
                    OP_SHR: begin
                        rf_wr_exec.en   = 1'b1;
                        rf_wr_exec.data = {1'b0, va[BYTE_W-1:1]};
                    end
                    OP_ANDI: begin
                        rf_wr_exec.en   = 1'b1;
                        rf_wr_exec.data = va & r_s1_item.imm;
                    end
                    OP_ORI: begin
                        rf_wr_exec.en   = 1'b1;
                        rf_wr_exec.data = va | r_s1_item.imm;
                    end
                    OP_XORI: begin
                        rf_wr_exec.en   = 1'b1;
                        rf_wr_exec.data = va ^ r_s1_item.imm;
                    end
                    OP_JMP: jump = 1'b1;
                    OP_JIZ: jump = (va == '0);
                    OP_JNZ: jump = (va != '0);
                    OP_JIC: jump = r_carry;
                    OP_JNC: jump = !r_carry;
                    OP_JII: jump = r_int;
                    OP_JNI: jump = !r_int;
                    OP_LDPR: begin
                        rf_wr_exec.en   = 1'b1;
                        rf_wr_exec.data = r_pc;
                    end
                    OP_LDFL: begin
                        rf_wr_exec.en = 1'b1;
                        rf_wr_exec.data[FLAG_CARRY] = r_carry;
                        rf_wr_exec.data[FLAG_NEG]   = r_neg;
                        rf_wr_exec.data[FLAG_INT]   = r_int;
                        rf_wr_exec.data[FLAG_HALT]  = r_halt;
                    end
                    OP_STFL: begin
                        n_carry = va[FLAG_CARRY];
                        n_neg   = va[FLAG_NEG];
                        n_int   = va[FLAG_INT];
                        n_halt  = va[FLAG_HALT];
                    end
                    OP_CALL: begin
                        // saves the address of the call itself
                        stk_ctl.push = 1'b1;
                        jump         = 1'b1;
                    end
                    OP_RET: begin
                        if (!stk_empty) begin
                            stk_ctl.pop = 1'b1;
                            pc_base     = stk_top;
                        end
                    end
                    OP_WR: begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = va;
                    end
                    OP_RD: begin
                        rf_wr_exec.en   = 1'b1;
                        rf_wr_exec.data = r_s1_item.in_byte;
                        res.in_taken    = 1'b1;
                    end
                    default: begin
                    end
                endcase
                n_pc = jump ? r_s1_item.imm : pc_base + 1'b1;
            end
            res.next_pc = n_pc;
            res.halted  = n_halt;
        end
    end

    // one write port: load writeback and execute never fall on the same edge
    always_comb begin
        if (r_s2_wb) begin
            rf_wr.en   = 1'b1;
            rf_wr.idx  = r_s2_idx;
            rf_wr.data = dmem_rdata;
        end else begin
            rf_wr = rf_wr_exec;
        end
    end

    // output buffer: result pushed at the end of execute
    assign push = r_s1_valid;
    assign pop  = (r_out_cnt != 2'd0) && i_out_ready;

    always_comb begin
        n_oq0     = r_oq0;
        n_oq1     = r_oq1;
        n_out_cnt = r_out_cnt + 2'(push) - 2'(pop);
        if (pop) begin
            n_oq0 = r_oq1;
        end
        if (push) begin
            if ((r_out_cnt - 2'(pop)) == 2'd0) begin
                n_oq0 = res;
            end else begin
                n_oq1 = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_wb     <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_cnt   <= 2'd0;
            r_pc        <= '0;
            r_carry     <= 1'b0;
            r_neg       <= 1'b0;
            r_int       <= 1'b0;
            r_halt      <= 1'b0;
        end else begin
            r_s1_valid  <= accept;
            r_s2_wb     <= n_s2_wb;
            r_fwd_valid <= r_s2_wb;
            r_out_cnt   <= n_out_cnt;
            r_pc        <= n_pc;
            r_carry     <= n_carry;
            r_neg       <= n_neg;
            r_int       <= n_int;
            r_halt      <= n_halt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= i_in_word;
        end
        r_s2_idx   <= r_s1_item.reg_a;
        r_fwd_idx  <= r_s2_idx;
        r_fwd_data <= dmem_rdata;
        r_oq0      <= n_oq0;
        r_oq1      <= n_oq1;
    end

    assign o_out_valid = (r_out_cnt != 2'd0);
    assign o_out_word  = r_oq0;

    `ASSERT_CLK(a_one_word_per_two, i_clk, i_rst_n, r_s1_valid |=> !r_s1_valid, "execute held two cycles")
    `ASSERT_NEVER(a_out_room, i_clk, i_rst_n, r_s1_valid && (r_out_cnt == 2'd2), "no room for result")
    `ASSERT_CLK(a_wb_after_exec, i_clk, i_rst_n, r_s2_wb |-> $past(r_s1_valid), "stray load writeback")
    `ASSERT_CLK(a_halt_holds_pc, i_clk, i_rst_n, (r_s1_valid && r_halt) |=> $stable(r_pc), "pc moved while halted")

endmodule

[tb/harvard_cpu_execute_unit_tb.sv]
// self-checking testbench for the harvard cpu execute unit
`timescale 1ns / 1ps

module harvard_cpu_execute_unit_tb;
    import hcpu_pkg::*;

    // run shape
    localparam int          RANDOM_WORDS = 400;
    localparam int          IDLE_LIMIT   = 2000; // covers the memory clearing pass and long hold
    localparam int          LONG_HOLD    = 300;  // receiver hold-off that backs the block up
    localparam int          HOLD_AT      = 150;  // result count at which that hold-off starts
    localparam int          STEADY_FROM  = 300;  // no idling on either side from here ...
    localparam int          STEADY_TO    = 360;  // ... up to here
    localparam int          DRAIN_CYCLES = 10;
    localparam logic [5:0]  OPCODE_TOP   = '1;   // highest opcode, acts as a no-op

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    // words still to be offered and results still owed by the block
    t_in_word  stim_words[$];
    t_out_word expected_results[$];

    int words_sent   = 0;
    int results_seen = 0;
    int error_count  = 0;
    int idle_cycles  = 0;
    int gap_left     = 0;
    int hold_left    = 0;

    // architectural state as the predictor sees it
    logic [7:0] cpu_regs[NUM_REGS_DEF];
    logic [7:0] cpu_mem[DATA_DEPTH_DEF];
    logic [7:0] ret_stack[STACK_DEPTH_DEF];
    int         ret_fill;
    logic [7:0] cpu_pc;
    logic       carry_f, neg_f, int_f, halt_f;

    harvard_cpu_execute_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // executes one word against the predictor state and returns the result it must give
    function automatic t_out_word execute_word(t_in_word w);
        t_out_word  res;
        logic [7:0] va, vb, rhs, nxt, flags;
        logic [8:0] sum;
        logic       jump;
        int         k;
        res  = '0;
        jump = 1'b0;
        if (w.req_type == REQ_PRELOAD) begin
            cpu_mem[w.imm] = w.in_byte;
        end else if (!halt_f) begin
            va  = cpu_regs[w.reg_a];
            vb  = cpu_regs[w.reg_b];
            nxt = cpu_pc;
            case (w.opcode)
                OP_ST:   cpu_mem[w.imm] = va;
                OP_STR:  cpu_mem[va] = vb;
                OP_LD:   cpu_regs[w.reg_a] = cpu_mem[w.imm];
                OP_LDR:  cpu_regs[w.reg_a] = cpu_mem[vb];
                OP_LI:   cpu_regs[w.reg_a] = w.imm;
                OP_CP:   cpu_regs[w.reg_a] = vb;
                OP_CLC:  carry_f = 1'b0;
                OP_CLI:  int_f = 1'b0;
                OP_CLN:  neg_f = 1'b0;
                OP_SUB, OP_SUBI: begin
                    // magnitude of the difference, sign goes to the negative flag
                    rhs   = (w.opcode == OP_SUB) ? vb : w.imm;
                    neg_f = va < rhs;
                    cpu_regs[w.reg_a] = neg_f ? rhs - va : va - rhs;
                end
                OP_ADD, OP_ADDI: begin
                    rhs     = (w.opcode == OP_ADD) ? vb : w.imm;
                    sum     = {1'b0, va} + {1'b0, rhs};
                    carry_f = sum[8];
                    cpu_regs[w.reg_a] = sum[7:0];
                end
                OP_AND:  cpu_regs[w.reg_a] = va & vb;
                OP_OR:   cpu_regs[w.reg_a] = va | vb;
                OP_XOR:  cpu_regs[w.reg_a] = va ^ vb;
                OP_NOT:  cpu_regs[w.reg_a] = ~va;
                OP_SHL:  cpu_regs[w.reg_a] = va << 1;
                OP_SHR:  cpu_regs[w.reg_a] = va >> 1;
                OP_ANDI: cpu_regs[w.reg_a] = va & w.imm;
                OP_ORI:  cpu_regs[w.reg_a] = va | w.imm;
                OP_XORI: cpu_regs[w.reg_a] = va ^ w.imm;
                OP_JMP:  jump = 1'b1;
                OP_JIZ:  jump = (va == 8'd0);
                OP_JNZ:  jump = (va != 8'd0);
                OP_JIC:  jump = carry_f;
                OP_JNC:  jump = !carry_f;
                OP_JII:  jump = int_f;
                OP_JNI:  jump = !int_f;
                OP_LDPR: cpu_regs[w.reg_a] = cpu_pc;
                OP_LDFL: begin
                    flags             = '0;
                    flags[FLAG_CARRY] = carry_f;
                    flags[FLAG_NEG]   = neg_f;
                    flags[FLAG_INT]   = int_f;
                    flags[FLAG_HALT]  = halt_f;
                    cpu_regs[w.reg_a] = flags;
                end
                OP_STFL: begin
                    carry_f = va[FLAG_CARRY];
                    neg_f   = va[FLAG_NEG];
                    int_f   = va[FLAG_INT];
                    halt_f  = va[FLAG_HALT];
                end
                OP_CALL: begin
                    // full stack drops its oldest entry
                    if (ret_fill < STACK_DEPTH_DEF) begin
                        ret_stack[ret_fill] = cpu_pc;
                        ret_fill++;
                    end else begin
                        for (k = 0; k < STACK_DEPTH_DEF - 1; k++)
                            ret_stack[k] = ret_stack[k + 1];
                        ret_stack[STACK_DEPTH_DEF - 1] = cpu_pc;
                    end
                    jump = 1'b1;
                end
                OP_RET: begin
                    // empty stack just steps on
                    if (ret_fill > 0) begin
                        ret_fill--;
                        nxt = ret_stack[ret_fill];
                    end
                end
                OP_WR: begin
                    res.tx_valid = 1'b1;
                    res.tx_byte  = va;
                end
                OP_RD: begin
                    cpu_regs[w.reg_a] = w.in_byte;
                    res.in_taken      = 1'b1;
                end
                default: ;
            endcase
            cpu_pc = jump ? w.imm : nxt + 8'd1;
        end
        res.next_pc = cpu_pc;
        res.halted  = halt_f;
        return res;
    endfunction

    // pause length: mostly short, now and then long
    function automatic int pick_pause();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    endfunction

    // byte with the extremes turning up often
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_word(logic kind, logic [5:0] op, logic [1:0] ra, logic [1:0] rb,
                              logic [7:0] imm, logic [7:0] ib);
        t_in_word w;
        w.req_type = kind;
        w.opcode   = op;
        w.reg_a    = ra;
        w.reg_b    = rb;
        w.imm      = imm;
        w.in_byte  = ib;
        stim_words.push_back(w);
    endtask

    task automatic queue_exec(logic [5:0] op, logic [1:0] ra, logic [7:0] imm);
        queue_word(REQ_EXEC, op, ra, 2'($urandom_range(0, 3)), imm, pick_byte());
    endtask

    // any instruction with random fields; a flag store is preceded by a load of its
    // operand with the halt bit clear, since halt cannot be left again without reset
    task automatic queue_random_instr();
        logic [5:0] op;
        logic [1:0] ra;
        logic [7:0] v;
        op = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(OP_RD + 1, OPCODE_TOP))
                                         : 6'($urandom_range(0, OP_RD));
        ra = 2'($urandom_range(0, 3));
        if (op == OP_STFL) begin
            v            = pick_byte();
            v[FLAG_HALT] = 1'b0;
            queue_exec(OP_LI, ra, v);
        end
        queue_word(REQ_EXEC, op, ra, 2'($urandom_range(0, 3)), pick_byte(), pick_byte());
    endtask

    task automatic report_mismatch(string msg);
        error_count++;
        $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // driver: offers words from the queue, predicts each one as it is taken
    always @(posedge i_clk) begin : word_driver
        bit fire;
        fire = i_in_valid && o_in_ready;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (fire) begin
                expected_results.push_back(execute_word(i_in_word));
                words_sent++;
                // no gaps inside the steady stretch
                if (words_sent >= STEADY_FROM && words_sent < STEADY_TO)
                    gap_left = 0;
                else
                    gap_left = ($urandom_range(0, 2) == 0) ? pick_pause() : 0;
            end
            if (!i_in_valid || fire) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (stim_words.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_word  <= stim_words.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result word against the oldest prediction, stalls at random
    always @(posedge i_clk) begin : result_monitor
        t_out_word want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    check_field("next_pc",  o_out_word.next_pc,  want.next_pc);
                    check_field("tx_valid", 8'(o_out_word.tx_valid), 8'(want.tx_valid));
                    check_field("tx_byte",  o_out_word.tx_byte,  want.tx_byte);
                    check_field("in_taken", 8'(o_out_word.in_taken), 8'(want.in_taken));
                    check_field("halted",   8'(o_out_word.halted),   8'(want.halted));
                end
                results_seen++;
                // one long hold-off so that the block fills and pushes back on its input
                if (results_seen == HOLD_AT)
                    hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if ((results_seen < STEADY_FROM || results_seen >= STEADY_TO) &&
                         $urandom_range(0, 3) == 0) begin
                hold_left = pick_pause() - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("harvard_cpu_execute_unit_tb: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int base;
        cpu_regs  = '{default: '0};
        cpu_mem   = '{default: '0};
        ret_stack = '{default: '0};
        ret_fill  = 0;
        cpu_pc    = '0;
        carry_f   = 1'b0;
        neg_f     = 1'b0;
        int_f     = 1'b0;
        halt_f    = 1'b0;

        // directed: preload extremes, every operation, flag and stack corners
        queue_word(REQ_PRELOAD, OP_NOOP, 2'd0, 2'd0, 8'hFF, 8'hFF);
        queue_word(REQ_PRELOAD, OPCODE_TOP, 2'd3, 2'd3, 8'h00, 8'h80);
        queue_exec(OP_LI,   2'd3, 8'hFF);
        queue_exec(OP_LD,   2'd1, 8'hFF);
        queue_exec(OP_LD,   2'd2, 8'h00);
        queue_word(REQ_EXEC, OP_ADD, 2'd3, 2'd1, 8'h00, 8'h00);   // carry out
        queue_exec(OP_JIC,  2'd0, 8'hFF);                         // taken, pc at top
        queue_exec(OP_ADDI, 2'd0, 8'h00);                         // pc wraps to zero
        queue_exec(OP_JNC,  2'd0, 8'h40);
        queue_exec(OP_JIZ,  2'd0, 8'h41);
        queue_exec(OP_JNZ,  2'd0, 8'h42);                         // not taken
        queue_exec(OP_SUBI, 2'd0, 8'hFF);                         // negative result
        queue_word(REQ_EXEC, OP_SUB, 2'd2, 2'd1, 8'h00, 8'h00);
        queue_word(REQ_EXEC, OP_CP,  2'd0, 2'd2, 8'h00, 8'h00);
        queue_word(REQ_EXEC, OP_AND, 2'd0, 2'd1, 8'h00, 8'h00);
        queue_word(REQ_EXEC, OP_OR,  2'd2, 2'd3, 8'h00, 8'h00);
        queue_word(REQ_EXEC, OP_XOR, 2'd1, 2'd1, 8'h00, 8'h00);
        queue_exec(OP_NOT,  2'd1, 8'h00);
        queue_exec(OP_SHL,  2'd1, 8'h00);
        queue_exec(OP_SHR,  2'd3, 8'h00);
        queue_exec(OP_ANDI, 2'd3, 8'hF0);
        queue_exec(OP_ORI,  2'd3, 8'h0F);
        queue_exec(OP_XORI, 2'd3, 8'hFF);
        queue_exec(OP_ST,   2'd3, 8'h10);
        queue_exec(OP_LI,   2'd1, 8'h10);
        queue_word(REQ_EXEC, OP_LDR, 2'd0, 2'd1, 8'h00, 8'h00);   // load then use at once
        queue_word(REQ_EXEC, OP_STR, 2'd0, 2'd3, 8'h00, 8'h00);
        queue_exec(OP_LI,   2'd2, 8'h07);                         // carry, negative, interrupt
        queue_exec(OP_STFL, 2'd2, 8'h00);
        queue_exec(OP_JII,  2'd0, 8'h20);
        queue_exec(OP_LDFL, 2'd0, 8'h00);
        queue_exec(OP_CLI,  2'd0, 8'h00);
        queue_exec(OP_JNI,  2'd0, 8'h30);
        queue_exec(OP_CLC,  2'd0, 8'h00);
        queue_exec(OP_CLN,  2'd0, 8'h00);
        queue_exec(OP_CALL, 2'd0, 8'h80);
        queue_exec(OP_CALL, 2'd0, 8'h90);
        queue_exec(OP_LDPR, 2'd1, 8'h00);
        repeat (3) queue_exec(OP_RET, 2'd0, 8'h00);               // last one on an empty stack
        queue_exec(OP_WR,   2'd3, 8'h00);
        queue_word(REQ_EXEC, OP_RD, 2'd2, 2'd0, 8'h00, 8'hA5);
        queue_exec(OP_NOOP, 2'd0, 8'h00);
        queue_exec(OPCODE_TOP, 2'd0, 8'h00);
        queue_exec(OP_JMP,  2'd0, 8'h00);

        // random: single instructions mixed with short well-formed sequences
        base = stim_words.size();
        while (stim_words.size() < base + RANDOM_WORDS) begin
            case ($urandom_range(0, 9))
                0: begin
                    // preload, then load from random addresses directly and through a register address
                    queue_word(REQ_PRELOAD, 6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)),
                               2'($urandom_range(0, 3)), pick_byte(), pick_byte());
                    queue_exec(OP_LD, 2'($urandom_range(0, 3)), pick_byte());
                    queue_exec(OP_LI, 2'd1, pick_byte());
                    queue_word(REQ_EXEC, OP_LDR, 2'($urandom_range(0, 3)), 2'd1, 8'h00, 8'h00);
                    queue_word(REQ_EXEC, OP_ADD, 2'($urandom_range(0, 3)),
                               2'($urandom_range(0, 3)), 8'h00, 8'h00);
                end
                1: begin
                    // call burst that can overflow the stack, then returns that can run past empty
                    repeat ($urandom_range(1, 20)) queue_exec(OP_CALL, 2'd0, pick_byte());
                    repeat ($urandom_range(0, 20)) queue_exec(OP_RET, 2'd0, pick_byte());
                end
                2, 3: begin
                    // set up a value and a flag, then a conditional branch
                    queue_exec(OP_LI, 2'd0, ($urandom_range(0, 2) == 0) ? 8'h00 : pick_byte());
                    queue_exec(($urandom_range(0, 1) == 0) ? OP_ADDI : OP_SUBI, 2'd0,
                               pick_byte());
                    queue_exec(6'($urandom_range(OP_JIZ, OP_JNI)), 2'd0, pick_byte());
                end
                default: queue_random_instr();
            endcase
        end

        // halt last: later executes are ignored, preloads still land
        queue_exec(OP_LI,   2'd0, 8'h0F);
        queue_exec(OP_STFL, 2'd0, 8'h00);
        queue_exec(OP_WR,   2'd0, 8'h00);
        queue_word(REQ_EXEC, OP_RD, 2'd1, 2'd0, 8'h00, 8'h5A);
        queue_exec(OP_STFL, 2'd1, 8'h00);
        queue_exec(OP_CALL, 2'd0, 8'h55);
        queue_word(REQ_PRELOAD, OP_NOOP, 2'd0, 2'd0, 8'h33, 8'hCC);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_words.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("harvard_cpu_execute_unit_tb: PASS");
        else
            $display("harvard_cpu_execute_unit_tb: FAIL");
        $finish;
    end

endmodule
